FILE: design/lennard_jones_pair_accumulator_macros.svh
// Assertion macros used by the block's control module.
`ifndef LENNARD_JONES_PAIR_ACCUMULATOR_MACROS_SVH
`define LENNARD_JONES_PAIR_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define LJPA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ljpa assertion failed");

// next-cycle implication
`define LJPA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ljpa assertion failed");

`endif

FILE: design/ljpa_pkg.sv
`default_nettype none
package ljpa_pkg;

   localparam logic [33:0]        CUTOFF_RESET = 34'd1638400;
   localparam logic [10:0]        MAX_PARTNERS = 11'd1024;
   localparam logic signed [63:0] LIM          = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] ONE          = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] MUL24        = 64'sh0000_0018_0000_0000;
   localparam logic signed [63:0] MUL4         = 64'sh0000_0004_0000_0000;
   localparam logic signed [63:0] TERM_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic [6:0]         DIV_LAST     = 7'd64;
   localparam logic [6:0]         SQ_LAST      = 7'd2;
   localparam logic [6:0]         MUL_WB       = 7'd5;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SQ   = 7'b0000010,
      ST_CHK  = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_ACC  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      OP_I2, OP_I3, OP_I4, OP_G, OP_G24, OP_E, OP_E4, OP_FX, OP_FY, OP_FZ
   } op_type;

   typedef struct packed {
      logic       load;
      logic       sq;
      logic [1:0] sq_sel;
      logic       div_step;
      logic       div_first;
      logic       inv_sat;
      logic       mul_ld;
      logic       mul_pp;
      logic [1:0] pp_idx;
      logic       mul_wb;
      op_type     op;
      logic       acc;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic small_d2;
      logic last;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

FILE: design/ljpa_ctrl.sv
`default_nettype none
`include "lennard_jones_pair_accumulator_macros.svh"
module ljpa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire ljpa_pkg::status_type status,
   output ljpa_pkg::cmd_type        cmd
);
   import ljpa_pkg::*;

   state_type  state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   op_type     op_ff, op_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.sq     = 1'b1;
            cmd.sq_sel = cnt_ff[1:0];
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = ST_CHK;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_CHK: begin
            cnt_in = '0;
            op_in  = OP_I2;
            if (!status.in_range) begin
               state_in = ST_FIN;
            end else if (status.small_d2) begin
               cmd.inv_sat = 1'b1;
               state_in    = ST_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               op_in    = OP_I2;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               cmd.mul_ld = 1'b1;
               cnt_in     = cnt_ff + 7'd1;
            end else if (cnt_ff == MUL_WB) begin
               cmd.mul_wb = 1'b1;
               cnt_in     = '0;
               if (op_ff == OP_FZ) begin
                  state_in = ST_ACC;
               end else begin
                  op_in = op_type'(op_ff + 4'd1);
               end
            end else begin
               cmd.mul_pp = 1'b1;
               cmd.pp_idx = 2'(cnt_ff - 7'd1);
               cnt_in     = cnt_ff + 7'd1;
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         op_ff    <= OP_I2;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
      end
   end

   `LJPA_ASSERT_NXT(a_accept_to_sq, clock, reset, req_tvalid && req_tready, state_ff == ST_SQ)
   `LJPA_ASSERT_NXT(a_div_to_mul, clock, reset, state_ff == ST_DIV && cnt_ff == DIV_LAST, state_ff == ST_MUL && op_ff == OP_I2 && cnt_ff == 7'd0)
   `LJPA_ASSERT_IMP(a_emit_ok, clock, reset, cmd.emit, status.last && !status.out_busy)

endmodule
`default_nettype wire

FILE: design/ljpa_dpath.sv
`default_nettype none
module ljpa_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [143:0]         req_tdata,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [207:0]              rsp_tdata,
   input  wire logic                 csr_wr_en,
   input  wire logic [33:0]          csr_wr_data,
   input  wire ljpa_pkg::cmd_type    cmd,
   output ljpa_pkg::status_type      status
);
   import ljpa_pkg::*;

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      mag = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [48:0] clamp_term(input logic signed [63:0] v);
      logic signed [63:0] neg_max;
      neg_max = -TERM_MAX;
      if (v > TERM_MAX) clamp_term = {1'b1, TERM_MAX[47:0]};
      else if (v < neg_max) clamp_term = {1'b1, neg_max[47:0]};
      else clamp_term = {1'b0, v[47:0]};
   endfunction

   function automatic logic [48:0] acc_add(input logic [47:0] a, input logic [47:0] b);
      logic signed [48:0] s;
      s = $signed({a[47], a}) + $signed({b[47], b});
      if (s > 49'sh0_7FFF_FFFF_FFFF) acc_add = {1'b1, 48'h7FFF_FFFF_FFFF};
      else if (s < -49'sh0_8000_0000_0000) acc_add = {1'b1, 48'h8000_0000_0000};
      else acc_add = {1'b0, s[47:0]};
   endfunction

   logic [33:0]        cutoff_ff;
   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic               last_ff;
   logic [49:0]        d2_ff, d2_in;
   logic [49:0]        rem_ff, rem_in;
   logic [62:0]        quo_ff, quo_in;
   logic signed [63:0] i2_ff, i3_ff, i4_ff, g_ff, e_ff, fx_ff, fy_ff, fz_ff;
   logic [62:0]        ma_ff, mb_ff;
   logic               neg_ff;
   logic [127:0]       prod_ff, prod_in;
   logic [47:0]        sx_ff, sy_ff, sz_ff, se_ff;
   logic [10:0]        pcnt_ff;
   logic               ovf_ff;
   logic               rsp_valid_ff;
   logic [207:0]       rsp_data_ff;

   // squares
   logic signed [24:0] sq_op;
   logic signed [49:0] sq_ext, sq_prod;
   always_comb begin
      case (cmd.sq_sel)
         2'd0:    sq_op = dx_ff;
         2'd1:    sq_op = dy_ff;
         default: sq_op = dz_ff;
      endcase
   end
   assign sq_ext  = 50'(sq_op);
   assign sq_prod = sq_ext * sq_ext;
   assign d2_in   = cmd.load ? '0 : (d2_ff + 50'(sq_prod));

   assign status.in_range = (d2_ff != '0) && (d2_ff <= {cutoff_ff, 16'd0});
   assign status.small_d2 = (d2_ff <= 50'd2);
   assign status.last     = last_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   // restoring divide of 2^64 by d2, one quotient bit a cycle
   logic [50:0] rs, rdiff;
   logic        ge;
   assign rs     = {rem_ff, cmd.div_first};
   assign rdiff  = rs - {1'b0, d2_ff};
   assign ge     = (rs >= {1'b0, d2_ff});
   assign rem_in = ge ? rdiff[49:0] : rs[49:0];
   assign quo_in = {quo_ff[61:0], ge};

   // multiplier operands
   logic signed [63:0] inv, a_sel, b_sel, dbl, tval;
   logic               dbl_sat;
   logic [63:0]        a_mag, b_mag;
   assign inv     = $signed({1'b0, quo_ff});
   assign dbl_sat = (i3_ff > (LIM - i3_ff));
   assign dbl     = dbl_sat ? LIM : (i3_ff + i3_ff);
   assign tval    = dbl - ONE;
   always_comb begin
      case (cmd.op)
         OP_I2:   begin a_sel = inv;   b_sel = inv;         end
         OP_I3:   begin a_sel = i2_ff; b_sel = inv;         end
         OP_I4:   begin a_sel = i2_ff; b_sel = i2_ff;       end
         OP_G:    begin a_sel = i4_ff; b_sel = tval;        end
         OP_G24:  begin a_sel = g_ff;  b_sel = MUL24;       end
         OP_E:    begin a_sel = i3_ff; b_sel = i3_ff - ONE; end
         OP_E4:   begin a_sel = e_ff;  b_sel = MUL4;        end
         OP_FX:   begin a_sel = g_ff;  b_sel = 64'(dx_ff);  end
         OP_FY:   begin a_sel = g_ff;  b_sel = 64'(dy_ff);  end
         default: begin a_sel = g_ff;  b_sel = 64'(dz_ff);  end
      endcase
   end
   assign a_mag = mag(a_sel);
   assign b_mag = mag(b_sel);

   // partial products
   logic [31:0] a_part, b_part;
   logic [63:0] pp;
   assign a_part = cmd.pp_idx[0] ? {1'b0, ma_ff[62:32]} : ma_ff[31:0];
   assign b_part = cmd.pp_idx[1] ? {1'b0, mb_ff[62:32]} : mb_ff[31:0];
   assign pp     = 64'(a_part) * 64'(b_part);
   always_comb begin
      case (cmd.pp_idx)
         2'd0:    prod_in = prod_ff + {64'd0, pp};
         2'd3:    prod_in = prod_ff + {pp, 64'd0};
         default: prod_in = prod_ff + {32'd0, pp, 32'd0};
      endcase
   end

   logic               m_sat;
   logic signed [63:0] m_r, m_res;
   assign m_sat = |prod_ff[127:95];
   assign m_r   = m_sat ? LIM : $signed({1'b0, prod_ff[94:32]});
   assign m_res = neg_ff ? -m_r : m_r;

   // accumulation
   logic [63:0]        e_mag;
   logic signed [63:0] e_sh, e_term;
   logic [48:0]        tx, ty, tz, te, ax, ay, az, ae;
   assign e_mag  = mag(e_ff);
   assign e_sh   = $signed(64'(e_mag[63:16]));
   assign e_term = e_ff[63] ? -e_sh : e_sh;
   assign tx = clamp_term(fx_ff);
   assign ty = clamp_term(fy_ff);
   assign tz = clamp_term(fz_ff);
   assign te = clamp_term(e_term);
   assign ax = acc_add(sx_ff, tx[47:0]);
   assign ay = acc_add(sy_ff, ty[47:0]);
   assign az = acc_add(sz_ff, tz[47:0]);
   assign ae = acc_add(se_ff, te[47:0]);

   logic sat_evt;
   assign sat_evt = cmd.inv_sat
                 || (cmd.mul_ld && cmd.op == OP_G && dbl_sat)
                 || (cmd.mul_wb && m_sat)
                 || (cmd.acc && (tx[48] || ty[48] || tz[48] || te[48]
                                 || ax[48] || ay[48] || az[48] || ae[48]));

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= CUTOFF_RESET;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sz_ff        <= '0;
         se_ff        <= '0;
         pcnt_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cutoff_ff <= csr_wr_data;
         if (sat_evt) ovf_ff <= 1'b1;
         if (cmd.acc) begin
            sx_ff <= ax[47:0];
            sy_ff <= ay[47:0];
            sz_ff <= az[47:0];
            se_ff <= ae[47:0];
            if (pcnt_ff < MAX_PARTNERS) pcnt_ff <= pcnt_ff + 11'd1;
         end
         if (cmd.emit) begin
            sx_ff        <= '0;
            sy_ff        <= '0;
            sz_ff        <= '0;
            se_ff        <= '0;
            pcnt_ff      <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         dx_ff   <= 25'(signed'(req_tdata[23:0]))  - 25'(signed'(req_tdata[95:72]));
         dy_ff   <= 25'(signed'(req_tdata[47:24])) - 25'(signed'(req_tdata[119:96]));
         dz_ff   <= 25'(signed'(req_tdata[71:48])) - 25'(signed'(req_tdata[143:120]));
         last_ff <= req_tlast;
      end
      if (cmd.load || cmd.sq) d2_ff <= d2_in;
      if (cmd.load) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.inv_sat) begin
         quo_ff <= '1;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mul_ld) begin
         ma_ff   <= a_mag[62:0];
         mb_ff   <= b_mag[62:0];
         neg_ff  <= a_sel[63] ^ b_sel[63];
         prod_ff <= '0;
      end else if (cmd.mul_pp) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_wb) begin
         case (cmd.op)
            OP_I2:           i2_ff <= m_res;
            OP_I3:           i3_ff <= m_res;
            OP_I4:           i4_ff <= m_res;
            OP_G, OP_G24:    g_ff  <= m_res;
            OP_E, OP_E4:     e_ff  <= m_res;
            OP_FX:           fx_ff <= m_res;
            OP_FY:           fy_ff <= m_res;
            default:         fz_ff <= m_res;
         endcase
      end
      if (cmd.emit) begin
         rsp_data_ff <= {4'd0, ovf_ff, pcnt_ff, se_ff, sz_ff, sy_ff, sx_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: design/lennard_jones_pair_accumulator.sv
// Lennard-Jones pair accumulator.
// req channel: one request per home/partner pair; tdata carries the two
// signed Q7.16 positions, tlast marks the home atom's final partner.
// rsp channel: one result per tlast request with the saturated Q31.16
// force and potential sums, the pair count and the saturation flag.
// csr port: csr_wr_en/csr_wr_data write the squared cutoff (Q.16).
// A request that falls outside the cutoff passes through the accept
// step, squaring on one 25x25 multiplier, a range check and the finish
// step. Any other request passes through the accept step, squaring, the
// range check, a one-bit-per-cycle divider for 1/d^2 (skipped for tiny
// distances), ten products on a shared 32x32 multiplier used as four
// partial products, an accumulate step and the finish step. One request
// is in flight at a time; req_tready is high only while the block is
// idle. The result sits in an output register; the next request is
// accepted while it waits. A tlast request whose result finds the
// register still full holds until rsp_tready drains it.
// Reset is synchronous: it clears the sums, count and flag, empties the
// output register and restores the cutoff to 25.0.
`default_nettype none
module lennard_jones_pair_accumulator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // own_x, own_y, own_z, partner_x, partner_y, partner_z
   input  wire logic [143:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // accel_x, accel_y, accel_z, potential, pairs_used, saturated, zero pad
   output logic [207:0]      rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [33:0]  csr_wr_data
);
   import ljpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   ljpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ljpa_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

FILE: bench/lennard_jones_pair_accumulator_checker.sv
`default_nettype none
module lennard_jones_pair_accumulator_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [143:0] req_tdata,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [207:0] rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [33:0]  csr_wr_data,
   output int                errors,
   output int                pending,
   output int                sums_seen
);
   import ljpa_pkg::*;

   // lowest field last so the layout matches rsp_tdata
   typedef struct packed {
      logic               sat;
      logic [10:0]        pairs;
      logic signed [47:0] pot;
      logic signed [47:0] az;
      logic signed [47:0] ay;
      logic signed [47:0] ax;
   } sums_type;

   sums_type           sums_q[$];
   logic [33:0]        cutoff;
   logic signed [63:0] sum_x, sum_y, sum_z, sum_e;
   logic [10:0]        pair_count;
   logic               sat_seen;
   logic               sat_now;

   assign pending = sums_q.size();

   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input int sh);
      logic [63:0]  ma, mb;
      logic [127:0] p;
      logic         neg;
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      p   = ({64'd0, ma} * {64'd0, mb}) >> sh;
      if (p > 128'(LIM)) begin
         sat_now = 1'b1;
         p = 128'(LIM);
      end
      return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(LIM)) begin
         sat_now = 1'b1;
         return LIM;
      end
      if (s < -65'(LIM)) begin
         sat_now = 1'b1;
         return -LIM;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] clip_term(input logic signed [63:0] v);
      if (v > TERM_MAX) begin
         sat_now = 1'b1;
         return TERM_MAX;
      end
      if (v < -TERM_MAX) begin
         sat_now = 1'b1;
         return -TERM_MAX;
      end
      return v;
   endfunction

   function automatic logic signed [63:0] acc_sat(input logic signed [63:0] acc,
                                                  input logic signed [63:0] t);
      logic signed [63:0] s;
      s = acc + t;
      if (s > TERM_MAX) begin
         sat_now = 1'b1;
         return TERM_MAX;
      end
      if (s < -(TERM_MAX + 1)) begin
         sat_now = 1'b1;
         return -(TERM_MAX + 1);
      end
      return s;
   endfunction

   function automatic void add_pair(input logic signed [63:0] dx,
                                    input logic signed [63:0] dy,
                                    input logic signed [63:0] dz);
      logic [63:0]        d2;
      logic [127:0]       q;
      logic signed [63:0] inv, i2, i3, i4, g, e;
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 == 0 || d2 > ({30'd0, cutoff} << 16)) return;
      if (d2 <= 1) begin
         sat_now = 1'b1;
         inv = LIM;
      end else begin
         q = (128'd1 << 64) / {64'd0, d2};
         if (q > 128'(LIM)) begin
            sat_now = 1'b1;
            q = 128'(LIM);
         end
         inv = q[63:0];
      end
      i2 = qmul(inv, inv, 32);
      i3 = qmul(i2, inv, 32);
      i4 = qmul(i2, i2, 32);
      g  = qmul(i4, qadd(qadd(i3, i3), -ONE), 32);
      g  = qmul(g, MUL24, 32);
      e  = qmul(i3, i3 - ONE, 32);
      e  = qmul(e, MUL4, 32);
      sum_x = acc_sat(sum_x, clip_term(qmul(g, dx, 32)));
      sum_y = acc_sat(sum_y, clip_term(qmul(g, dy, 32)));
      sum_z = acc_sat(sum_z, clip_term(qmul(g, dz, 32)));
      sum_e = acc_sat(sum_e, clip_term(qmul(e, 64'sd1, 16)));
      if (pair_count < MAX_PARTNERS) pair_count++;
   endfunction

   task automatic note_bad(input string what, input logic [63:0] want,
                           input logic [63:0] got);
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      sums_type want, got, fresh;
      if (reset) begin
         cutoff     <= CUTOFF_RESET;
         sum_x = 0; sum_y = 0; sum_z = 0; sum_e = 0;
         pair_count = 0;
         sat_seen   = 1'b0;
         sums_q.delete();
      end else begin
         if (csr_wr_en) cutoff <= csr_wr_data;
         if (req_tvalid && req_tready) begin
            sat_now = 1'b0;
            add_pair(64'($signed(req_tdata[23:0]))   - 64'($signed(req_tdata[95:72])),
                     64'($signed(req_tdata[47:24]))  - 64'($signed(req_tdata[119:96])),
                     64'($signed(req_tdata[71:48]))  - 64'($signed(req_tdata[143:120])));
            if (sat_now) sat_seen = 1'b1;
            if (req_tlast) begin
               fresh.ax    = sum_x[47:0];
               fresh.ay    = sum_y[47:0];
               fresh.az    = sum_z[47:0];
               fresh.pot   = sum_e[47:0];
               fresh.pairs = pair_count;
               fresh.sat   = sat_seen;
               sums_q      = {sums_q, fresh};
               sum_x = 0; sum_y = 0; sum_z = 0; sum_e = 0;
               pair_count = 0;
               sat_seen   = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[203:0];
            sums_seen++;
            if (sums_q.size() == 0) begin
               $display("%0t unexpected result %h", $time, got);
               errors++;
            end else begin
               want = sums_q.pop_front();
               if (want.ax != got.ax) note_bad("accel_x", 64'(want.ax), 64'(got.ax));
               if (want.ay != got.ay) note_bad("accel_y", 64'(want.ay), 64'(got.ay));
               if (want.az != got.az) note_bad("accel_z", 64'(want.az), 64'(got.az));
               if (want.pot != got.pot) note_bad("potential", 64'(want.pot), 64'(got.pot));
               if (want.pairs != got.pairs)
                  note_bad("pairs_used", 64'(want.pairs), 64'(got.pairs));
               if (want.sat != got.sat) note_bad("saturated", 64'(want.sat), 64'(got.sat));
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: bench/lennard_jones_pair_accumulator_test.sv
`default_nettype none
module lennard_jones_pair_accumulator_test;
   import ljpa_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [33:0]  csr_wr_data = '0;
   int           errors, pending, sums_seen;
   int           requests = 0;
   bit           steady = 1'b0;

   always #4 clock = ~clock;

   lennard_jones_pair_accumulator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   lennard_jones_pair_accumulator_checker u_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .errors(errors), .pending(pending), .sums_seen(sums_seen)
   );

   // one pair request; home/partner packed low to high
   task automatic send_pair(input logic [23:0] ox, oy, oz, px, py, pz,
                            input logic last);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pz, py, px, oz, oy, ox};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      requests++;
   endtask

   // partner offset by a random delta of up to span on each axis
   task automatic send_near(input int span, input logic last);
      logic [23:0] ox, oy, oz;
      ox = 24'($urandom); oy = 24'($urandom); oz = 24'($urandom);
      send_pair(ox, oy, oz,
                ox + 24'($urandom_range(0, 2 * span) - span),
                oy + 24'($urandom_range(0, 2 * span) - span),
                oz + 24'($urandom_range(0, 2 * span) - span), last);
   endtask

   task automatic set_cutoff(input logic [33:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (140) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_runs(input int count);
      int n, span;
      repeat (count) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               0:       send_pair(24'($urandom), 24'($urandom), 24'($urandom),
                                  24'($urandom), 24'($urandom), 24'($urandom),
                                  i == n - 1);
               1:       send_near(2, i == n - 1);
               default: begin
                  span = $urandom_range(0, 1) ? 400000 : 100000;
                  send_near(span, i == n - 1);
               end
            endcase
         end
      end
   endtask

   always begin
      @(posedge clock);
      if (steady) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default cutoff
      send_pair(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
      send_pair(24'h010000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0);
      send_pair(24'h0, 24'h018000, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0);
      send_pair(24'h0, 24'h0, 24'h050000, 24'h0, 24'h0, 24'h0, 1'b1);
      send_pair(24'h0, 24'h0, 24'h050001, 24'h0, 24'h0, 24'h0, 1'b1);
      send_pair(24'h000001, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0);
      send_pair(24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'h0, 1'b1);
      send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE, 1'b1);
      send_pair(24'h004000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);

      set_cutoff(34'h3_FFFF_FFFF);
      send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
      send_pair(24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
      send_pair(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0);
      send_pair(24'h000100, 24'h000100, 24'h000100, 24'h0, 24'h0, 24'h0, 1'b1);
      random_runs(35);

      set_cutoff(34'd0);
      send_pair(24'h000001, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
      random_runs(12);

      set_cutoff(CUTOFF_RESET);
      random_runs(25);

      set_cutoff(34'($urandom_range(100000, 10000000)));
      random_runs(18);

      steady = 1'b1;
      set_cutoff(34'd65536);
      random_runs(12);

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("pair requests: %0d, sums checked: %0d, cutoffs zero/25/max/random/1",
               requests, sums_seen);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
